@@ rtl/core/tridiagonal_system_solver_defines.svh @@
// assertion macros for the tridiagonal solver
// used by files that carry concurrent checks
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_DEFINES_SVH
`define TDS_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("assertion failed");
`define TDS_ASSERT_NR(lbl, clk_s, prop) \
    lbl: assert property (@(posedge clk_s) prop) else $error("assertion failed");
`endif

@@ rtl/core/tds_pkg.sv @@
// shared types, constants and arithmetic helpers for the tridiagonal solver
// no dependencies
`timescale 1ns / 1ps
package tds_pkg;
    localparam int MAX_ROWS = 64;
    localparam int WORD_BITS = 32;
    localparam int FRACTION_BITS = 16;
    localparam int IDX_BITS = $clog2(MAX_ROWS);
    localparam int CNT_BITS = IDX_BITS + 1;
    localparam int QUO_BITS = WORD_BITS + FRACTION_BITS;
    localparam int QCNT_BITS = $clog2(QUO_BITS + 1);

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic signed [31:0] sub_coeff;
        logic signed [31:0] diag_coeff;
        logic signed [31:0] super_coeff;
        logic signed [31:0] rhs_value;
        logic last_row;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic [5:0] row_index;
        logic last_out;
        logic divide_fault;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_MUL, ST_ADD, ST_DIVP, ST_DIVQ, ST_WR,
        ST_BRD, ST_BMUL, ST_BADD, ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_READ, OP_MUL, OP_ADD, OP_DIVP_START, OP_DIVQ_START,
        OP_WRITE, OP_BREAD, OP_BMUL, OP_BADD, OP_BLOAD, OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
        logic [IDX_BITS-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic last_row;
        logic row_fault;
    } status_t;

    function automatic word_t sat_add(word_t a, word_t b, logic sub);
        logic signed [WORD_BITS:0] s;
        s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
                : ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                : {1'b0, {(WORD_BITS-1){1'b1}}};
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_mag(logic [2*WORD_BITS-1:0] m, logic neg);
        logic [2*WORD_BITS-1:0] lim;
        lim = neg ? (2*WORD_BITS)'(1) << (WORD_BITS-1)
                  : ((2*WORD_BITS)'(1) << (WORD_BITS-1)) - 1'b1;
        if (m > lim)
            m = lim;
        return neg ? word_t'(-m[WORD_BITS-1:0]) : word_t'(m[WORD_BITS-1:0]);
    endfunction
endpackage

@@ rtl/core/tridiagonal_system_solver.sv @@
// top level of the tridiagonal solver
// depends on tds_pkg, tds_controller, tds_datapath
//  channel | dir | handshake                 | word
//  in      | in  | in_valid / in_ready       | tds_pkg::in_word_t
//  out     | out | out_valid / out_ready     | tds_pkg::out_word_t
// from acceptance to the next in_ready a stored row runs two serial divides with 48-bit
// quotients, one quotient bit per cycle, and the sequencing states around them
// a zero pivot ends both divides at once
// after the last row, each solution word passes the read, multiply, add and emit states
// one row in flight at a time; out stalls hold the sequencer
// reset clears counters and the fault flag; row stores need no clearing
`timescale 1ns / 1ps
module tridiagonal_system_solver (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  tds_pkg::in_word_t in_word,
    output logic out_valid,
    input  logic out_ready,
    output tds_pkg::out_word_t out_word
);
    tds_pkg::cmd_t cmd;
    tds_pkg::status_t status;
    logic fault;

    tds_controller u_ctl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd),
        .fault_out(fault)
    );

    tds_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_word(in_word), .status(status),
        .result(out_word), .result_fault(fault)
    );
endmodule

@@ rtl/core/tds_divider.sv @@
// restoring serial divider, one quotient bit per cycle, saturating signed q format
// depends on tds_pkg
`timescale 1ns / 1ps
module tds_divider (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  tds_pkg::word_t num,
    input  tds_pkg::word_t den,
    input  logic flip,
    output logic busy,
    output logic fault,
    output tds_pkg::word_t quo
);
    localparam int W = tds_pkg::WORD_BITS;
    localparam int QB = tds_pkg::QUO_BITS;
    logic [tds_pkg::QCNT_BITS-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [QB-1:0] shq_reg, shq_next;
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] dm_reg, dm_next;
    logic neg_reg, neg_next;
    logic [W:0] trial;
    logic nsign;
    logic [W-1:0] nm;

    always_comb
    begin
        nsign = num[W-1] ^ flip;
        nm = num[W-1] ? W'(-num) : W'(num);
        trial = {rem_reg, shq_reg[QB-1]} - {1'b0, dm_reg};
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        shq_next = shq_reg;
        rem_next = rem_reg;
        dm_next = dm_reg;
        neg_next = neg_reg;
        if (start)
        begin
            busy_next = (den != '0);
            cnt_next = tds_pkg::QCNT_BITS'(QB);
            shq_next = {nm, {tds_pkg::FRACTION_BITS{1'b0}}};
            rem_next = '0;
            dm_next = den[W-1] ? W'(-den) : W'(den);
            neg_next = nsign ^ den[W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[W])
                rem_next = trial[W-1:0];
            else
                rem_next = {rem_reg[W-2:0], shq_reg[QB-1]};
            shq_next = {shq_reg[QB-2:0], ~trial[W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tds_pkg::QCNT_BITS'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            fault <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
            if (start)
                fault <= (den == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        shq_reg <= shq_next;
        rem_reg <= rem_next;
        dm_reg <= dm_next;
        neg_reg <= neg_next;
    end

    logic zero_reg, zneg_reg;
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (nm == '0);
            zneg_reg <= nsign;
        end
    end

    always_comb
    begin
        busy = busy_reg;
        if (fault)
            quo = zero_reg ? '0 : (zneg_reg ? {1'b1, {(W-1){1'b0}}}
                                            : {1'b0, {(W-1){1'b1}}});
        else
            quo = tds_pkg::sat_mag({{(2*W-QB){1'b0}}, shq_reg}, neg_reg);
    end
endmodule

@@ rtl/core/tds_datapath.sv @@
// row stores, multiplier, adder and divider of the tridiagonal solver
// depends on tds_pkg, tds_divider
`timescale 1ns / 1ps
`include "tridiagonal_system_solver_defines.svh"
module tds_datapath (
    input  logic clk,
    input  logic rst_n,
    input  tds_pkg::cmd_t cmd,
    input  tds_pkg::in_word_t in_word,
    output tds_pkg::status_t status,
    output tds_pkg::out_word_t result,
    input  logic result_fault
);
    localparam int W = tds_pkg::WORD_BITS;
    localparam int F = tds_pkg::FRACTION_BITS;
    tds_pkg::word_t p_mem [tds_pkg::MAX_ROWS];
    tds_pkg::word_t q_mem [tds_pkg::MAX_ROWS];
    tds_pkg::in_word_t row_reg;
    tds_pkg::word_t prd_reg, qrd_reg, pf_reg, mp_reg, mq_reg, den_reg, num_reg, x_reg;
    logic [tds_pkg::IDX_BITS-1:0] addr_reg;
    logic div_start, div_busy, div_fault, div_flip;
    tds_pkg::word_t div_num, div_quo;
    logic first_reg;
    logic rowf_reg;

    function automatic tds_pkg::word_t fx_mul(tds_pkg::word_t x, tds_pkg::word_t y);
        logic [W-1:0] xm, ym;
        logic [2*W-1:0] p;
        xm = x[W-1] ? W'(-x) : W'(x);
        ym = y[W-1] ? W'(-y) : W'(y);
        p = (2*W)'(xm) * (2*W)'(ym) + ((2*W)'(1) << (F-1));
        return tds_pkg::sat_mag(p >> F, x[W-1] ^ y[W-1]);
    endfunction

    always_comb
    begin
        div_start = (cmd.op == tds_pkg::OP_DIVP_START) || (cmd.op == tds_pkg::OP_DIVQ_START);
        div_flip = (cmd.op == tds_pkg::OP_DIVP_START);
        div_num = div_flip ? (row_reg.last_row ? '0 : row_reg.super_coeff) : num_reg;
    end

    tds_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(den_reg),
        .flip(div_flip), .busy(div_busy), .fault(div_fault), .quo(div_quo)
    );

    logic fault_acc;
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            tds_pkg::OP_LOAD:
            begin
                row_reg <= in_word;
                first_reg <= (cmd.addr == '0);
            end
            tds_pkg::OP_READ, tds_pkg::OP_BREAD:
            begin
                prd_reg <= p_mem[cmd.addr];
                qrd_reg <= q_mem[cmd.addr];
                addr_reg <= cmd.addr;
            end
            tds_pkg::OP_MUL:
            begin
                mp_reg <= fx_mul(row_reg.sub_coeff, prd_reg);
                mq_reg <= fx_mul(row_reg.sub_coeff, qrd_reg);
            end
            tds_pkg::OP_ADD:
            begin
                den_reg <= first_reg ? row_reg.diag_coeff
                                     : tds_pkg::sat_add(row_reg.diag_coeff, mp_reg, 1'b0);
                num_reg <= first_reg ? row_reg.rhs_value
                                     : tds_pkg::sat_add(row_reg.rhs_value, mq_reg, 1'b1);
            end
            tds_pkg::OP_DIVQ_START:
            begin
                pf_reg <= div_quo;
                fault_acc <= div_fault;
            end
            tds_pkg::OP_WRITE:
            begin
                p_mem[cmd.addr] <= pf_reg;
                q_mem[cmd.addr] <= div_quo;
            end
            tds_pkg::OP_BMUL:
                mp_reg <= fx_mul(prd_reg, x_reg);
            tds_pkg::OP_BLOAD:
                x_reg <= qrd_reg;
            tds_pkg::OP_BADD:
                x_reg <= tds_pkg::sat_add(mp_reg, qrd_reg, 1'b0);
            default:
            begin
            end
        endcase
    end

    logic wr_fault;
    assign wr_fault = fault_acc | div_fault;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rowf_reg <= 1'b0;
        else if (cmd.op == tds_pkg::OP_WRITE)
            rowf_reg <= wr_fault;
        else if (cmd.op == tds_pkg::OP_EMIT && addr_reg == '0)
            rowf_reg <= 1'b0;
    end

    always_comb
    begin
        status.div_busy = div_busy;
        status.last_row = row_reg.last_row;
        status.row_fault = rowf_reg;
        result.solution_value = x_reg;
        result.row_index = 6'(addr_reg);
        result.last_out = (addr_reg == '0);
        result.divide_fault = result_fault;
    end

    `TDS_ASSERT(a_div_idle_start, clk, rst_n, div_start |-> !div_busy)
    `TDS_ASSERT(a_write_after_div, clk, rst_n, (cmd.op == tds_pkg::OP_WRITE) |-> !div_busy)
    `TDS_ASSERT(a_div_runs, clk, rst_n,
        (div_start && den_reg != '0) |=> div_busy)
endmodule

@@ rtl/core/tds_controller.sv @@
// sequencer for forward elimination and back substitution
// depends on tds_pkg
`timescale 1ns / 1ps
`include "tridiagonal_system_solver_defines.svh"
module tds_controller (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  tds_pkg::status_t status,
    output tds_pkg::cmd_t cmd,
    output logic fault_out
);
    tds_pkg::state_t state_reg, state_next;
    logic [tds_pkg::CNT_BITS-1:0] rows_reg, rows_next;
    logic [tds_pkg::IDX_BITS-1:0] bidx_reg, bidx_next;
    logic fault_reg, fault_next, bfirst_reg, bfirst_next;
    logic full;

    assign full = (rows_reg == tds_pkg::CNT_BITS'(tds_pkg::MAX_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tds_pkg::ST_IDLE;
            rows_reg <= '0;
            bidx_reg <= '0;
            fault_reg <= 1'b0;
            bfirst_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg <= rows_next;
            bidx_reg <= bidx_next;
            fault_reg <= fault_next;
            bfirst_reg <= bfirst_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rows_next = rows_reg;
        bidx_next = bidx_reg;
        fault_next = fault_reg;
        bfirst_next = bfirst_reg;
        cmd.op = tds_pkg::OP_NONE;
        cmd.addr = rows_reg[tds_pkg::IDX_BITS-1:0];
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            tds_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = tds_pkg::OP_LOAD;
                    state_next = tds_pkg::ST_RD;
                end
            end
            tds_pkg::ST_RD:
            begin
                if (full)
                begin
                    if (status.last_row)
                    begin
                        bidx_next = tds_pkg::IDX_BITS'(rows_reg - 1'b1);
                        bfirst_next = 1'b1;
                        state_next = tds_pkg::ST_BRD;
                    end
                    else
                        state_next = tds_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.op = tds_pkg::OP_READ;
                    cmd.addr = rows_reg[tds_pkg::IDX_BITS-1:0] - 1'b1;
                    state_next = tds_pkg::ST_MUL;
                end
            end
            tds_pkg::ST_MUL:
            begin
                cmd.op = tds_pkg::OP_MUL;
                state_next = tds_pkg::ST_ADD;
            end
            tds_pkg::ST_ADD:
            begin
                cmd.op = tds_pkg::OP_ADD;
                state_next = tds_pkg::ST_DIVP;
            end
            tds_pkg::ST_DIVP:
            begin
                cmd.op = tds_pkg::OP_DIVP_START;
                state_next = tds_pkg::ST_DIVQ;
            end
            tds_pkg::ST_DIVQ:
            begin
                if (!status.div_busy)
                begin
                    cmd.op = tds_pkg::OP_DIVQ_START;
                    state_next = tds_pkg::ST_WR;
                end
            end
            tds_pkg::ST_WR:
            begin
                if (!status.div_busy)
                begin
                    cmd.op = tds_pkg::OP_WRITE;
                    rows_next = rows_reg + 1'b1;
                    state_next = tds_pkg::ST_EMIT;
                    if (status.last_row)
                    begin
                        bidx_next = rows_reg[tds_pkg::IDX_BITS-1:0];
                        bfirst_next = 1'b1;
                    end
                end
            end
            tds_pkg::ST_BRD:
            begin
                cmd.op = tds_pkg::OP_BREAD;
                cmd.addr = bidx_reg;
                state_next = tds_pkg::ST_BMUL;
            end
            tds_pkg::ST_BMUL:
            begin
                cmd.op = tds_pkg::OP_BMUL;
                state_next = tds_pkg::ST_BADD;
            end
            tds_pkg::ST_BADD:
            begin
                cmd.op = bfirst_reg ? tds_pkg::OP_BLOAD : tds_pkg::OP_BADD;
                state_next = tds_pkg::ST_EMIT;
                bfirst_next = 1'b0;
            end
            tds_pkg::ST_EMIT:
            begin
                fault_next = fault_reg | status.row_fault;
                if (!status.last_row)
                    state_next = tds_pkg::ST_IDLE;
                else if (bfirst_reg)
                    state_next = tds_pkg::ST_BRD;
                else
                begin
                    out_valid = 1'b1;
                    if (out_ready)
                    begin
                        cmd.op = tds_pkg::OP_EMIT;
                        if (bidx_reg == '0)
                        begin
                            rows_next = '0;
                            fault_next = 1'b0;
                            state_next = tds_pkg::ST_IDLE;
                        end
                        else
                        begin
                            bidx_next = bidx_reg - 1'b1;
                            state_next = tds_pkg::ST_BRD;
                        end
                    end
                end
            end
            default:
                state_next = tds_pkg::ST_IDLE;
        endcase
    end

    assign fault_out = fault_reg | status.row_fault;

    `TDS_ASSERT(a_rows_bound, clk, rst_n,
        rows_reg <= tds_pkg::CNT_BITS'(tds_pkg::MAX_ROWS))
    `TDS_ASSERT(a_no_both, clk, rst_n, !(in_ready && out_valid))
    `TDS_ASSERT(a_emit_clears, clk, rst_n,
        (out_valid && out_ready && bidx_reg == '0) |=> (rows_reg == '0))
endmodule

@@ sim/tb_tridiagonal_system_solver.sv @@
// self-checking testbench for tridiagonal_system_solver: rows of directed and random systems are driven
// through valid/ready and every solution word is checked against a fixed-point Thomas predictor
// depends on tds_pkg and the tridiagonal_system_solver rtl
`timescale 1ns / 1ps
module tb_tridiagonal_system_solver;
    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    tds_pkg::in_word_t in_word;
    logic out_valid;
    logic out_ready;
    tds_pkg::out_word_t out_word;

    tridiagonal_system_solver DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word(out_word)
    );

    tds_pkg::in_word_t row_q[$];
    bit drain_q[$];
    tds_pkg::out_word_t solution_q[$];

    logic signed [31:0] factor_mem[tds_pkg::MAX_ROWS];
    logic signed [31:0] reduced_mem[tds_pkg::MAX_ROWS];
    int held_rows;
    bit pivot_fault;
    int errors;
    int gap_left;
    int burst_left;
    int ready_mode;
    int ready_timer;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint clamp_word(longint v);
        if (v > WMAX)
            return WMAX;
        if (v < WMIN)
            return WMIN;
        return v;
    endfunction

    function automatic logic signed [31:0] q_mul(logic signed [31:0] x, logic signed [31:0] y);
        longint mx;
        longint my;
        longint p;
        bit neg;
        mx = x;
        my = y;
        neg = (mx < 0) != (my < 0);
        if (mx < 0)
            mx = -mx;
        if (my < 0)
            my = -my;
        p = (mx * my + 64'sd32768) >>> tds_pkg::FRACTION_BITS;
        return 32'(clamp_word(neg ? -p : p));
    endfunction

    function automatic logic signed [31:0] q_add(logic signed [31:0] x, logic signed [31:0] y,
                                                 bit sub);
        longint s;
        s = sub ? longint'(x) - longint'(y) : longint'(x) + longint'(y);
        return 32'(clamp_word(s));
    endfunction

    function automatic logic signed [31:0] q_div(logic signed [31:0] n, logic signed [31:0] d,
                                                 bit flip, inout bit fault);
        longint nm;
        longint dm;
        longint q;
        bit nneg;
        bit neg;
        nm = n;
        dm = d;
        nneg = (nm < 0) != flip;
        neg = nneg != (dm < 0);
        if (nm < 0)
            nm = -nm;
        if (dm < 0)
            dm = -dm;
        if (dm == 0)
        begin
            fault = 1'b1;
            if (nm == 0)
                return 32'sd0;
            return nneg ? 32'(WMIN) : 32'(WMAX);
        end
        q = (nm <<< tds_pkg::FRACTION_BITS) / dm;
        return 32'(clamp_word(neg ? -q : q));
    endfunction

    task automatic solve_row(tds_pkg::in_word_t w);
        logic signed [31:0] c;
        logic signed [31:0] pivot;
        logic signed [31:0] num;
        logic signed [31:0] x;
        tds_pkg::out_word_t r;
        bit f;
        int n;
        int i;
        f = 1'b0;
        x = '0;
        if (held_rows < tds_pkg::MAX_ROWS)
        begin
            c = w.last_row ? 32'sd0 : w.super_coeff;
            if (held_rows == 0)
            begin
                pivot = w.diag_coeff;
                num = w.rhs_value;
            end
            else
            begin
                pivot = q_add(w.diag_coeff, q_mul(w.sub_coeff, factor_mem[held_rows-1]), 1'b0);
                num = q_add(w.rhs_value, q_mul(w.sub_coeff, reduced_mem[held_rows-1]), 1'b1);
            end
            factor_mem[held_rows] = q_div(c, pivot, 1'b1, f);
            reduced_mem[held_rows] = q_div(num, pivot, 1'b0, f);
            if (f)
                pivot_fault = 1'b1;
            held_rows++;
        end
        if (w.last_row)
        begin
            n = held_rows;
            for (i = n - 1; i >= 0; i--)
            begin
                if (i == n - 1)
                    x = reduced_mem[i];
                else
                    x = q_add(q_mul(factor_mem[i], x), reduced_mem[i], 1'b0);
                r.solution_value = x;
                r.row_index = 6'(i);
                r.last_out = (i == 0);
                r.divide_fault = pivot_fault;
                solution_q = {solution_q, r};
            end
            held_rows = 0;
            pivot_fault = 1'b0;
        end
    endtask

    function automatic void add_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] d, bit last, bit drain);
        tds_pkg::in_word_t w;
        w.sub_coeff = a;
        w.diag_coeff = b;
        w.super_coeff = c;
        w.rhs_value = d;
        w.last_row = last;
        row_q = {row_q, w};
        drain_q = {drain_q, drain};
    endfunction

    function automatic logic [31:0] small_coeff();
        return 32'($signed($urandom_range(131072)) - 65536);
    endfunction

    // random system; mostly diagonally dominant so values stay inside the word
    function automatic void add_system(int len, bit drain);
        int k;
        bit tame;
        logic [31:0] b;
        tame = ($urandom_range(9) < 7);
        for (k = 0; k < len; k++)
        begin
            if (tame)
            begin
                b = 32'($urandom_range(4, 8) << 16) + 32'($urandom_range(65535));
                if ($urandom_range(1))
                    b = -b;
                add_row(small_coeff(), b, small_coeff(),
                        32'($signed($urandom_range(2097152)) - 1048576),
                        k == len - 1, drain && k == 0);
            end
            else
                add_row($urandom, $urandom, $urandom, $urandom, k == len - 1, drain && k == 0);
        end
    endfunction

    // sender: bursts with gaps, and a pause for a full drain on flagged rows
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
            gap_left <= 0;
            burst_left <= 4;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (row_q.size() > 0 && !(drain_q[0] && (in_valid || solution_q.size() != 0)))
            begin
                in_word <= row_q.pop_front();
                void'(drain_q.pop_front());
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 80);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_mode <= 0;
            ready_timer <= 0;
        end
        else
        begin
            if (ready_timer == 0)
            begin
                ready_mode <= $urandom_range(3);
                ready_timer <= $urandom_range(20, 300);
            end
            else
                ready_timer <= ready_timer - 1;
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(1);
                2: out_ready <= ($urandom_range(3) == 0);
                default: out_ready <= ($urandom_range(9) != 0);
            endcase
        end
    end

    // prediction on accepted rows, checking on accepted solution words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                solve_row(in_word);
            if (out_valid && out_ready)
            begin
                if (solution_q.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, got %h", $time, out_word);
                    errors++;
                end
                else if (out_word != solution_q[0])
                begin
                    $display("%0t mismatch: expected val %h idx %0d last %b fault %b",
                             $time, solution_q[0].solution_value, solution_q[0].row_index,
                             solution_q[0].last_out, solution_q[0].divide_fault);
                    $display("%0t            actual val %h idx %0d last %b fault %b",
                             $time, out_word.solution_value, out_word.row_index,
                             out_word.last_out, out_word.divide_fault);
                    errors++;
                    void'(solution_q.pop_front());
                end
                else
                    void'(solution_q.pop_front());
            end
        end
    end

    initial
    begin
        int rows;
        errors = 0;
        held_rows = 0;
        pivot_fault = 1'b0;
        rst_n = 1'b0;

        // single row systems, including zero pivots of each numerator sign
        add_row(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'h0003_0000, 1'b1, 1'b0);
        add_row(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1, 1'b0);
        add_row(32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 1'b1, 1'b0);
        add_row(32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
        // field extremes
        add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        add_row(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0);
        add_row(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
        // ordinary three-row system with a negative pivot in the middle
        add_row(32'h0, 32'h0004_0000, 32'h0001_0000, 32'h0002_0000, 1'b0, 1'b0);
        add_row(32'h0001_0000, 32'hFFFF_C000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0);
        add_row(32'h0001_0000, 32'h0003_0000, 32'h0, 32'hFFFE_0000, 1'b1, 1'b0);
        add_system(3, 1'b1);
        add_system(2, 1'b0);
        // full store, then one with rows dropped past the limit
        add_system(tds_pkg::MAX_ROWS, 1'b1);
        add_system(tds_pkg::MAX_ROWS + 2, 1'b0);
        rows = row_q.size();
        while (rows < 260)
        begin
            int len;
            len = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
            add_system(len, $urandom_range(9) == 0);
            rows += len;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (row_q.size() == 0);
        @(posedge clk);
        wait (!in_valid && solution_q.size() == 0);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("PASS tridiagonal_system_solver");
        else
            $display("FAIL tridiagonal_system_solver");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL tridiagonal_system_solver");
        $finish;
    end
endmodule
